>>> rtl/ihc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ihc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HDR     = 2'd1;

  localparam logic [3:0] EXP_VERSION_RST = 4'd4;
  localparam logic [5:0] MIN_HDR_RST     = 6'd20;

  // status codes, first failing check wins
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_VERSION    = 3'd1;
  localparam logic [2:0] ST_HDR_SHORT  = 3'd2;
  localparam logic [2:0] ST_HDR_BEYOND = 3'd3;
  localparam logic [2:0] ST_TOT_BELOW  = 3'd4;
  localparam logic [2:0] ST_TOT_BEYOND = 3'd5;

  localparam logic [15:0] CKSUM_GOOD = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_packet;
    logic [15:0] pkt_bytes;
  } in_item_t;

  typedef struct packed {
    logic        basic_ok;
    logic        checksum_ok;
    logic [2:0]  status;
    logic [3:0]  version;
    logic [5:0]  header_bytes;
    logic [15:0] ip_tot_len;
  } out_item_t;

  // handshake between input register and header core
  typedef struct packed {
    logic item_vld;
    logic advance;
  } proc_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ihc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ihc_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ihc_pkg::in_item_t in_data,
  input  wire logic             advance,
  output ihc_pkg::in_item_t     item,
  output logic                  item_vld
);
  import ihc_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     take;

  // hold the byte while the core cannot consume it
  assign in_stall = vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (take) begin
      item_r <= in_data;
    end
  end

  assign item     = item_r;
  assign item_vld = vld_r;

endmodule

`default_nettype wire

>>> rtl/ihc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ihc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ihc_pkg::in_item_t  item,
  input  wire ihc_pkg::proc_ctl_t ctl,
  input  wire logic [3:0]        exp_ver,
  input  wire logic [5:0]        min_hdr,
  output ihc_pkg::out_item_t     result,
  output logic                   emit
);
  import ihc_pkg::*;

  function automatic logic [2:0] basic_status(
    input logic [3:0]  ver,
    input logic [3:0]  ev,
    input logic [5:0]  hbc,
    input logic [5:0]  mh,
    input logic [15:0] pkt,
    input logic [15:0] tot
  );
    logic [2:0] st;
    if (ver != ev) begin
      st = ST_VERSION;
    end else if (hbc < mh) begin
      st = ST_HDR_SHORT;
    end else if ({10'd0, hbc} > pkt) begin
      st = ST_HDR_BEYOND;
    end else if (tot < {10'd0, hbc}) begin
      st = ST_TOT_BELOW;
    end else if (tot > pkt) begin
      st = ST_TOT_BEYOND;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  logic        in_hdr_r, in_hdr_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [5:0]  hbc_r, hbc_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [15:0] pkt_r, pkt_nxt;

  logic [5:0]  hbc_new;
  logic        early;
  logic [16:0] wsum;
  logic        last;
  logic        emit_raw;
  logic [2:0]  st;

  assign hbc_new = {item.data_byte[3:0], 2'b00};
  assign early   = (hbc_new < min_hdr) || ({10'd0, hbc_new} > item.pkt_bytes) ||
                   (hbc_new == 6'd0);
  // end-around carry add keeps the ones-complement sum folded
  assign wsum    = {1'b0, acc_r} + {1'b0, hi_r, item.data_byte};
  assign last    = ({1'b0, idx_r} + 7'd1) >= {1'b0, hbc_r};

  always_comb begin
    in_hdr_nxt = in_hdr_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    hi_nxt     = hi_r;
    ver_nxt    = ver_r;
    hbc_nxt    = hbc_r;
    tot_nxt    = tot_r;
    pkt_nxt    = pkt_r;
    emit_raw   = 1'b0;
    result     = '0;
    if (item.start_of_packet) begin
      pkt_nxt    = item.pkt_bytes;
      ver_nxt    = item.data_byte[7:4];
      hbc_nxt    = hbc_new;
      acc_nxt    = '0;
      tot_nxt    = '0;
      hi_nxt     = item.data_byte;
      idx_nxt    = 6'd1;
      in_hdr_nxt = !early;
      emit_raw   = early;
      st = basic_status(ver_nxt, exp_ver, hbc_new, min_hdr, item.pkt_bytes, 16'd0);
      result.basic_ok     = (st == ST_OK);
      result.checksum_ok  = 1'b0;
      result.status       = st;
      result.version      = ver_nxt;
      result.header_bytes = hbc_new;
      result.ip_tot_len   = '0;
    end else begin
      st = basic_status(ver_r, exp_ver, hbc_r, min_hdr, pkt_r, tot_r);
      if (in_hdr_r) begin
        if (idx_r == 6'd2) begin
          tot_nxt = {item.data_byte, tot_r[7:0]};
        end else if (idx_r == 6'd3) begin
          tot_nxt = {tot_r[15:8], item.data_byte};
        end
        if (idx_r[0]) begin
          acc_nxt = wsum[15:0] + {15'd0, wsum[16]};
        end else begin
          hi_nxt = item.data_byte;
        end
        if (last) begin
          in_hdr_nxt = 1'b0;
          idx_nxt    = '0;
          emit_raw   = 1'b1;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
        st = basic_status(ver_r, exp_ver, hbc_r, min_hdr, pkt_r, tot_nxt);
      end
      result.basic_ok     = (st == ST_OK);
      result.checksum_ok  = (acc_nxt == CKSUM_GOOD);
      result.status       = st;
      result.version      = ver_r;
      result.header_bytes = hbc_r;
      result.ip_tot_len   = tot_nxt;
    end
  end

  assign emit = ctl.item_vld && emit_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hdr_r <= 1'b0;
      idx_r    <= '0;
    end else if (ctl.advance) begin
      in_hdr_r <= in_hdr_nxt;
      idx_r    <= idx_nxt;
    end
    if (ctl.advance) begin
      acc_r <= acc_nxt;
      hi_r  <= hi_nxt;
      ver_r <= ver_nxt;
      hbc_r <= hbc_nxt;
      tot_r <= tot_nxt;
      pkt_r <= pkt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ihc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ihc_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire ihc_pkg::out_item_t  result,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ihc_pkg::out_item_t      out_data
);
  import ihc_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t data_r;

  // room when empty or the held result leaves this cycle
  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> rtl/ipv4_header_checker_unit.sv
// a byte passes the input register, the core, then the result register
// throughput: one packet byte per cycle, but a result-producing byte waits
//   on a full, stalled result register
// reset: synchronous, active low; clears the handshake and header tracking,
//   loads expected version 4 and minimum header length 20
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_checker_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // packet byte channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ihc_pkg::in_item_t                 in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ihc_pkg::out_item_t                     out_data,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ihc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ihc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ihc_pkg::*;

  // configuration registers
  logic [3:0] exp_ver_r;
  logic [5:0] min_hdr_r;

  // input register outputs
  in_item_t   item;
  logic       item_vld;

  // core and output register hookup
  proc_ctl_t  ctl;
  out_item_t  result;
  logic       emit;
  logic       out_free;
  logic       proc_go;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= EXP_VERSION_RST;
      min_hdr_r <= MIN_HDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXP_VERSION: exp_ver_r <= cfg_wdata[3:0];
        REG_MIN_HDR:     min_hdr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the core consumes the held byte unless it produces a result
  // while the output register is full and stalled
  assign proc_go      = item_vld && (!emit || out_free);
  assign ctl.item_vld = item_vld;
  assign ctl.advance  = proc_go;

  ihc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (proc_go),
    .item     (item),
    .item_vld (item_vld)
  );

  // header tracking, checksum accumulation and status decision
  ihc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .ctl     (ctl),
    .exp_ver (exp_ver_r),
    .min_hdr (min_hdr_r),
    .result  (result),
    .emit    (emit)
  );

  // result register: parts the result side from the byte side
  ihc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_go && emit),
    .result    (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a result-producing byte waits while the held result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && emit && out_valid && out_stall) |-> in_stall)
    else $error("result would overwrite a stalled result");

  // a good checksum needs a non-empty header
  a_cksum_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.checksum_ok) |-> (out_data.header_bytes != 6'd0))
    else $error("checksum reported good for empty header");

  // status code stays within the defined set and agrees with basic_ok
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_TOT_BEYOND) &&
                  (out_data.basic_ok == (out_data.status == ST_OK)))
    else $error("bad status on result");

  // a version write lands in the register on the next edge
  a_cfg_ver: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == REG_EXP_VERSION)) |=>
      (exp_ver_r == $past(cfg_wdata[3:0])))
    else $error("expected version write lost");

endmodule

`default_nettype wire

>>> dv/header_verdict_check.sv
`timescale 1ns / 1ps

module header_verdict_check (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  ihc_pkg::in_item_t                  in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  ihc_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [ihc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ihc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                 fail_count,
  output int                                 verdicts_owed
);

  // register copies
  logic [3:0]  want_version;
  logic [5:0]  min_hdr;

  // header tracking
  logic        hdr_open;
  logic [5:0]  pos;
  logic [20:0] word_sum;
  logic [7:0]  hi_byte;
  logic [3:0]  seen_version;
  logic [5:0]  hdr_len;
  logic [15:0] tot_len;
  logic [15:0] pkt_len;

  ihc_pkg::out_item_t owed_verdicts[$];
  int errors = 0;

  function automatic logic [2:0] header_status();
    if (seen_version != want_version) return ihc_pkg::ST_VERSION;
    if (hdr_len < min_hdr) return ihc_pkg::ST_HDR_SHORT;
    if (hdr_len > pkt_len) return ihc_pkg::ST_HDR_BEYOND;
    if (tot_len < hdr_len) return ihc_pkg::ST_TOT_BELOW;
    if (tot_len > pkt_len) return ihc_pkg::ST_TOT_BEYOND;
    return ihc_pkg::ST_OK;
  endfunction

  function automatic void push_verdict(logic cks_ok, logic [15:0] total);
    ihc_pkg::out_item_t v;
    v.status       = header_status();
    v.basic_ok     = (v.status == ihc_pkg::ST_OK);
    v.checksum_ok  = cks_ok;
    v.version      = seen_version;
    v.header_bytes = hdr_len;
    v.ip_tot_len   = total;
    owed_verdicts.push_back(v);
  endfunction

  function automatic void absorb_byte(ihc_pkg::in_item_t req);
    logic [20:0] folded;
    if (req.start_of_packet) begin
      pkt_len      = req.pkt_bytes;
      seen_version = req.data_byte[7:4];
      hdr_len      = {req.data_byte[3:0], 2'b00};
      word_sum     = '0;
      tot_len      = '0;
      hi_byte      = req.data_byte;
      pos          = 6'd1;
      hdr_open     = 1'b0;
      // length failures and empty headers report on the start byte
      if (hdr_len < min_hdr || hdr_len > pkt_len || hdr_len == 6'd0)
        push_verdict(1'b0, 16'd0);
      else
        hdr_open = 1'b1;
    end else if (hdr_open) begin
      if (pos == 6'd2) tot_len[15:8] = req.data_byte;
      else if (pos == 6'd3) tot_len[7:0] = req.data_byte;
      if (pos[0]) word_sum = word_sum + {5'd0, hi_byte, req.data_byte};
      else hi_byte = req.data_byte;
      if (int'(pos) + 1 >= int'(hdr_len)) begin
        folded = word_sum;
        while (folded[20:16] != 5'd0)
          folded = {5'd0, folded[15:0]} + {16'd0, folded[20:16]};
        push_verdict(folded[15:0] == ihc_pkg::CKSUM_GOOD && folded[20:16] == 5'd0, tot_len);
        hdr_open = 1'b0;
        pos      = 6'd0;
      end else begin
        pos = pos + 6'd1;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(ihc_pkg::out_item_t got);
    ihc_pkg::out_item_t want;
    if (owed_verdicts.size() == 0) begin
      $error("result with nothing expected: %0h", got);
      errors++;
      return;
    end
    want = owed_verdicts.pop_front();
    check_field("basic_ok", 16'(want.basic_ok), 16'(got.basic_ok));
    check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
    check_field("status", 16'(want.status), 16'(got.status));
    check_field("version", 16'(want.version), 16'(got.version));
    check_field("header_bytes", 16'(want.header_bytes), 16'(got.header_bytes));
    check_field("ip_tot_len", want.ip_tot_len, got.ip_tot_len);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      want_version = ihc_pkg::EXP_VERSION_RST;
      min_hdr      = ihc_pkg::MIN_HDR_RST;
      hdr_open     = 1'b0;
      pos          = '0;
      word_sum     = '0;
      hi_byte      = '0;
      seen_version = '0;
      hdr_len      = '0;
      tot_len      = '0;
      pkt_len      = '0;
      owed_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ihc_pkg::REG_EXP_VERSION: want_version = cfg_wdata[3:0];
          ihc_pkg::REG_MIN_HDR:     min_hdr = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_byte(in_data);
    end
    fail_count    <= errors;
    verdicts_owed <= owed_verdicts.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // allowance for a result to show after its byte, padded on top in the drain
  localparam int RESULT_LATENCY = 2;
  // cycles with no request moving on any channel before giving up
  localparam int QUIET_LIMIT    = 2000;
  // long receiver hold-off so the result path backs up into the input
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  ihc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ihc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ihc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ihc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int verdicts_owed;

  // idling knobs: sender side is read only by the stimulus process,
  // receiver side is handed over with nonblocking writes
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  logic hold_trig = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left   = 0;

  // what the stimulus believes the registers hold, used to shape headers
  logic [3:0] cur_version = ihc_pkg::EXP_VERSION_RST;
  logic [5:0] cur_min_hdr = ihc_pkg::MIN_HDR_RST;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ipv4_header_checker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  header_verdict_check checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  // receiver: a toggle of hold_trig starts a long hold-off, otherwise
  // stall at random with the current rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_trig;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // watchdog on cycles where no request moves anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one byte request, with random idle cycles ahead of it
  task automatic send_byte(input ihc_pkg::in_item_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // register write; caller drops cfg_valid after its last write
  task automatic cfg_write(input logic [ihc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ihc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // builds a header with random filler, optionally patches the checksum
  // word so the folded sum comes out all ones, sends the first n_send bytes
  task automatic send_packet(input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tot, input logic [15:0] plen,
                             input bit fix_sum, input int n_send);
    logic [7:0]  hdr [60];
    logic [16:0] acc;
    ihc_pkg::in_item_t req;
    int hb;
    hb = int'(ihl) * 4;
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = {ver, ihl};
    if (hb >= 4) begin
      hdr[2] = tot[15:8];
      hdr[3] = tot[7:0];
    end
    if (fix_sum && hb >= 12) begin
      hdr[10] = 8'd0;
      hdr[11] = 8'd0;
      acc = '0;
      for (int i = 0; i < hb; i += 2) begin
        acc = acc + {1'b0, hdr[i], hdr[i+1]};
        acc = {1'b0, acc[15:0]} + 17'(acc[16]);
      end
      {hdr[10], hdr[11]} = ~acc[15:0];
    end
    for (int i = 0; i < n_send; i++) begin
      req.data_byte       = hdr[i];
      req.start_of_packet = (i == 0);
      // length is only sampled on the start byte, junk elsewhere
      req.pkt_bytes       = (i == 0) ? plen : 16'($urandom);
      send_byte(req);
    end
    bytes_sent += n_send;
  endtask

  // mostly well-formed headers for the current settings, with some wrong
  // versions, odd lengths, bad checksums, cut-short headers and trailing
  // stray bytes mixed in
  task automatic random_packet();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tot;
    logic [15:0] plen;
    ihc_pkg::in_item_t stray;
    int lo, hb, n_send, r;
    ver = ($urandom_range(99) < 85) ? cur_version : 4'($urandom);
    lo = (int'(cur_min_hdr) + 3) / 4;
    if (lo == 0) lo = 1;
    // keep most headers near the shortest legal size
    r = $urandom_range(99);
    if (r < 70) ihl = 4'($urandom_range(lo, (lo < 15) ? lo + 1 : 15));
    else if (r < 85) ihl = 4'($urandom_range(lo, 15));
    else ihl = 4'($urandom);
    hb = int'(ihl) * 4;
    r = $urandom_range(99);
    if (r < 70) tot = 16'(hb + $urandom_range(0, 40));
    else if (r < 85) tot = 16'($urandom_range(0, hb));
    else tot = 16'($urandom);
    r = $urandom_range(99);
    if (r < 70) plen = tot;
    else if (r < 80) plen = tot - 16'($urandom_range(1, 8));
    else if (r < 90) plen = 16'($urandom);
    else plen = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    n_send = (hb == 0) ? 1 : hb;
    // restart: next start byte lands in the middle of this header
    if (hb > 1 && $urandom_range(99) < 5) n_send = $urandom_range(1, hb - 1);
    send_packet(ver, ihl, tot, plen, $urandom_range(99) < 85, n_send);
    repeat ($urandom_range(0, 2)) begin
      stray.data_byte       = 8'($urandom);
      stray.start_of_packet = 1'b0;
      stray.pkt_bytes       = 16'($urandom);
      send_byte(stray);
    end
  endtask

  // a start byte with a zero-length header always reports at once, so no
  // header is left open; then wait for every result and the pipe to empty
  task automatic drain_results();
    ihc_pkg::in_item_t req;
    req.data_byte       = {cur_version, 4'h0};
    req.start_of_packet = 1'b1;
    req.pkt_bytes       = 16'($urandom);
    send_byte(req);
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] ver, input logic [5:0] min_len,
                           input int tx_pct, input int rx_pct,
                           input int n_bytes, input bit hold);
    int start_count;
    // upper data bits are don't-care for the version register
    cfg_write(ihc_pkg::REG_EXP_VERSION, {2'($urandom), ver});
    cfg_write(ihc_pkg::REG_MIN_HDR, min_len);
    cfg_valid    <= 1'b0;
    cur_version  = ver;
    cur_min_hdr  = min_len;
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
    if (hold) hold_trig <= ~hold_trig;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) random_packet();
    drain_results();
  endtask

  initial begin
    ihc_pkg::in_item_t req;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, under reset register values
    // stray byte before any header
    req = '{data_byte: 8'hFF, start_of_packet: 1'b0, pkt_bytes: 16'hFFFF};
    send_byte(req);
    // header longer than a zero-length packet
    req = '{data_byte: 8'h45, start_of_packet: 1'b1, pkt_bytes: 16'h0000};
    send_byte(req);
    // header shorter than the minimum
    req = '{data_byte: 8'h41, start_of_packet: 1'b1, pkt_bytes: 16'hFFFF};
    send_byte(req);
    // wrong version on an early report wins over the length codes
    req = '{data_byte: 8'hFF, start_of_packet: 1'b1, pkt_bytes: 16'h0000};
    send_byte(req);
    // clean 20-byte header with a good checksum
    send_packet(4'd4, 4'd5, 16'd20, 16'd20, 1'b1, 20);
    drain_results();

    // random phases over register settings and idling mixes
    run_phase(4'd4, 6'd20, 0, 0, 150, 1'b1);
    run_phase(4'd0, 6'd0, 54, 0, 200, 1'b0);
    run_phase(4'd15, 6'd60, 0, 54, 150, 1'b0);
    run_phase(4'($urandom), 6'($urandom_range(0, 60)), 13, 13, 200, 1'b0);
    run_phase(4'd4, 6'd20, 0, 0, 150, 1'b0);
    run_phase(4'($urandom), 6'd24, 13, 13, 150, 1'b0);

    if (fail_count == 0 && verdicts_owed == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
